/* sv/tfa_pkg.sv */
// Shared constants, types and the reciprocal table for the temporal frame averager.
// No dependencies; imported by the top level temporal_frame_averager.
`timescale 1ns / 1ps

package tfa_pkg;

    localparam int MAX_FRAMES   = 8;
    localparam int MAX_WIDTH    = 256;
    localparam int MAX_HEIGHT   = 256;
    localparam int CHANNEL_MAX  = 255;
    localparam int FRAME_PIXELS = MAX_WIDTH * MAX_HEIGHT;

    localparam int POS_W   = $clog2(FRAME_PIXELS);
    localparam int SLOT_W  = $clog2(MAX_FRAMES);
    localparam int CNT_W   = 4;
    localparam int DIM_W   = 9;
    localparam int CH_W    = 8;
    localparam int PIX_W   = 4 * CH_W;
    localparam int SUM_W   = CH_W + SLOT_W;
    localparam int RECIP_W = 17;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int AVG_W   = PROD_W - 16;
    localparam int IDX_W   = 2;

    typedef enum logic [IDX_W-1:0] {
        REG_FRAME_COUNT  = 2'd0,
        REG_FRAME_WIDTH  = 2'd1,
        REG_FRAME_HEIGHT = 2'd2
    } reg_index_t;

    typedef logic [PIX_W-1:0] pixel_t;
    typedef logic [SUM_W-1:0] sum_t;

    // ceil(2^16 / count); exact truncating division for sums below 2^SUM_W.
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
        logic [RECIP_W-1:0] r;
        case (count)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8192;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

endpackage

/* sv/tfa_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module tfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/temporal_frame_averager.sv */
// Top level of the temporal frame averager: frame ring, summing and division pipeline.
// Depends on tfa_pkg and tfa_ram.
`timescale 1ns / 1ps

// Usage:
// Pixels arrive on the s_ stream, one RGBA pixel per transaction (red in the
// lowest byte). Each pixel is stored in the current slot of a ring of frames,
// and the pixel at the same raster position is averaged over the first
// frame_count slots. The averaged pixel leaves on the m_ stream, with m_tlast
// high on the last pixel of a frame.
// Throughput is one pixel per cycle when neither back-pressure nor the clearing
// pass holds the input: each frame slot is its own RAM bank, so all slots are
// read in the cycle the pixel is written.
// A result is valid after the RAM read, channel sums, reciprocal multiply and
// clip into the output register, each held in its own register.
// After reset every bank is cleared, one address per cycle in all banks at
// once over all 65536 addresses, with s_tready low until the pass ends. Register
// writes on the cfg_ port are taken at any time but belong to idle periods.
// When the receiver holds m_tready low with a result waiting, the whole
// pipeline holds and s_tready drops; nothing is lost or repeated.

module temporal_frame_averager
    import tfa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [PIX_W-1:0]     s_tdata,   // pixel_r, pixel_g, pixel_b, pixel_a
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [PIX_W-1:0]     m_tdata,   // avg_r, avg_g, avg_b, avg_a
    output logic                 m_tlast,   // last_of_frame
    input  logic                 cfg_we,
    input  logic [IDX_W-1:0]     cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    logic [CNT_W-1:0]  count_reg;
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              clr_busy_reg;
    logic [POS_W-1:0]  clr_addr_reg;

    logic              v1_reg, v2_reg, v3_reg, out_v_reg;
    pixel_t            pix1_reg;
    logic [SLOT_W-1:0] slot1_reg;
    logic [CNT_W-1:0]  cnt1_reg, cnt2_reg;
    logic              last1_reg, last2_reg, last3_reg, out_last_reg;
    sum_t              sum2_reg [4];
    logic [AVG_W-1:0]  avg3_reg [4];
    pixel_t            out_data_reg;

    logic              advance, accept;
    logic [CNT_W-1:0]  eff_count, new_count;
    logic [DIM_W-1:0]  eff_w, eff_h;
    logic [2*DIM_W-1:0] area;
    logic [2*DIM_W-1:0] last_pos;
    logic [SLOT_W-1:0] cur_slot;
    logic              is_last;
    logic [SLOT_W:0]   slot_inc;
    pixel_t            bank_rdata [MAX_FRAMES];
    sum_t              sum_next [4];
    logic [PROD_W-1:0] prod [4];
    pixel_t            clip_next;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (v > CNT_W'(MAX_FRAMES)) begin
            r = CNT_W'(MAX_FRAMES);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    assign advance   = !out_v_reg || m_tready;
    assign s_tready  = advance && !clr_busy_reg;
    assign accept    = s_tvalid && s_tready;

    assign eff_count = clamp_count(count_reg);
    assign new_count = clamp_count(cfg_data[CNT_W-1:0]);
    assign eff_w     = clamp_dim(width_reg, DIM_W'(MAX_WIDTH));
    assign eff_h     = clamp_dim(height_reg, DIM_W'(MAX_HEIGHT));
    assign area      = eff_w * eff_h;
    assign last_pos  = area - (2*DIM_W)'(1);
    assign cur_slot  = ({1'b0, slot_reg} >= (SLOT_W+1)'(eff_count)) ? '0 : slot_reg;
    assign is_last   = (2*DIM_W)'(pos_reg) >= last_pos;
    assign slot_inc  = {1'b0, cur_slot} + (SLOT_W+1)'(1);

    // Control state: registers, raster position, write slot and clearing pass.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= CNT_W'(1);
            width_reg    <= DIM_W'(256);
            height_reg   <= DIM_W'(256);
            slot_reg     <= '0;
            pos_reg      <= '0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            if (clr_busy_reg) begin
                clr_addr_reg <= clr_addr_reg + POS_W'(1);
                if (clr_addr_reg == POS_W'(FRAME_PIXELS - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (cfg_we) begin
                case (reg_index_t'(cfg_index))
                    REG_FRAME_COUNT: begin
                        count_reg <= cfg_data[CNT_W-1:0];
                        if ({1'b0, slot_reg} >= (SLOT_W+1)'(new_count)) begin
                            slot_reg <= '0;
                        end
                    end
                    REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                    REG_FRAME_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                if (is_last) begin
                    pos_reg  <= '0;
                    slot_reg <= (slot_inc >= (SLOT_W+1)'(eff_count)) ? '0
                                                                     : slot_inc[SLOT_W-1:0];
                end else begin
                    pos_reg  <= pos_reg + POS_W'(1);
                    slot_reg <= cur_slot;
                end
            end
        end
    end

    // One bank per frame slot; all banks are read at the current position.
    for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_bank
        logic bank_we;
        assign bank_we = clr_busy_reg || (accept && cur_slot == SLOT_W'(i));
        tfa_ram #(
            .WIDTH(PIX_W),
            .DEPTH(FRAME_PIXELS)
        ) u_bank (
            .aclk (aclk),
            .we   (bank_we),
            .waddr(clr_busy_reg ? clr_addr_reg : pos_reg),
            .wdata(clr_busy_reg ? '0 : s_tdata),
            .re   (advance),
            .raddr(pos_reg),
            .rdata(bank_rdata[i])
        );
    end

    // The bank being written returns stale data, so the new pixel is used in its place.
    always_comb begin
        pixel_t px;
        for (int c = 0; c < 4; c++) begin
            sum_next[c] = '0;
        end
        for (int s = 0; s < MAX_FRAMES; s++) begin
            px = (slot1_reg == SLOT_W'(s)) ? pix1_reg : bank_rdata[s];
            if ((SLOT_W+1)'(s) < (SLOT_W+1)'(cnt1_reg)) begin
                for (int c = 0; c < 4; c++) begin
                    sum_next[c] = sum_next[c] + SUM_W'(px[c*CH_W +: CH_W]);
                end
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            prod[c] = PROD_W'(sum2_reg[c]) * PROD_W'(recip(cnt2_reg));
            clip_next[c*CH_W +: CH_W] = (avg3_reg[c] > AVG_W'(CHANNEL_MAX))
                                      ? CH_W'(CHANNEL_MAX) : avg3_reg[c][CH_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end else if (advance) begin
            v1_reg    <= accept;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            out_v_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            pix1_reg     <= s_tdata;
            slot1_reg    <= cur_slot;
            cnt1_reg     <= eff_count;
            last1_reg    <= is_last;
            sum2_reg     <= sum_next;
            cnt2_reg     <= cnt1_reg;
            last2_reg    <= last1_reg;
            for (int c = 0; c < 4; c++) begin
                avg3_reg[c] <= prod[c][PROD_W-1:16];
            end
            last3_reg    <= last2_reg;
            out_data_reg <= clip_next;
            out_last_reg <= last3_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule
